// ----- design/prd_pkg.sv -----
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants of the pixel map run decoder: image formats,
// register indexes, field widths and the decoder state and run records.
// ----------------------------------------------------------------------------
package prd_pkg;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 25;
   localparam int FMT_W   = 2;
   localparam int CODE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int CODES   = 4;
   localparam int IDX_W   = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [32:0] MaxPixels = 33'd16777216;

   localparam logic [FMT_W-1:0] FMT_RAW  = 2'd0;
   localparam logic [FMT_W-1:0] FMT_RLE  = 2'd1;
   localparam logic [FMT_W-1:0] FMT_RLE1 = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_FORMAT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_COUNT  = 1'd1;

   typedef struct packed {
      logic [COUNT_W-1:0] pixels_left;
      logic               expect_count;
      logic [WORD_W-1:0]  held_pixel;
      logic [WORD_W-1:0]  fore_colour;
      logic               need_fore;
   } state_type;

   typedef struct packed {
      logic               emit;
      logic               word_done;
      logic [WORD_W-1:0]  pixel_value;
      logic [COUNT_W-1:0] run_length;
      logic               image_done;
      logic               last_of_word;
   } run_type;

endpackage

// ----- design/prd_req_if.sv -----
// ----------------------------------------------------------------------------
// prd_req_if
// Input word channel of the pixel map run decoder.
// ----------------------------------------------------------------------------
interface prd_req_if;
   logic                       valid;
   logic                       ready;
   logic [prd_pkg::WORD_W-1:0] data_word;
   logic                       image_start;

   modport source (output valid, output data_word, output image_start, input ready);
   modport sink   (input valid, input data_word, input image_start, output ready);
endinterface

// ----- design/prd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// prd_rsp_if
// Pixel run channel of the pixel map run decoder.
// ----------------------------------------------------------------------------
interface prd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [prd_pkg::WORD_W-1:0]  pixel_value;
   logic [prd_pkg::COUNT_W-1:0] run_length;
   logic                        image_done;
   logic                        last_of_word;

   modport source (output valid, output pixel_value, output run_length,
                   output image_done, output last_of_word, input ready);
   modport sink   (input valid, input pixel_value, input run_length,
                   input image_done, input last_of_word, output ready);
endinterface

// ----- design/pixmap_run_decoder_core.sv -----
// ----------------------------------------------------------------------------
// pixmap_run_decoder_core
// Decodes the words of a compressed image into ARGB pixel runs.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*     : write image_format and pixel_count while the decoder is idle.
//   req_chan  : 32-bit stream words; image_start marks the first word of an
//               image and reloads the pixel count.
//   rsp_chan  : pixel runs (value, length, image done, last of word).
// Timing:
//   A word is taken into a one-word buffer and decoded one code per cycle
//   while the output is not stalled; its runs pass from the buffer through
//   the result register. Raw and RLE words are decoded in a single step, so
//   a word may follow in every cycle while runs are accepted. An RLE1 code
//   word is decoded one packed code at a time, up to its last code.
//   A new word is taken in the cycle the buffered word finishes, while the
//   last run still waits in the result register.
// Reset:
//   CSRs, valid flags, word index and decoder state clear; nothing is pending.
// Stall:
//   With rsp_chan.ready low the result holds and decoding pauses at the
//   next run; the word buffer then fills and req_chan.ready drops.
// ----------------------------------------------------------------------------
module pixmap_run_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [prd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [prd_pkg::COUNT_W-1:0]       csr_wdata,
   prd_req_if.sink                           req_chan,
   prd_rsp_if.source                         rsp_chan
);

   logic [prd_pkg::FMT_W-1:0]   format_ff;
   logic [prd_pkg::COUNT_W-1:0] count_ff;

   logic                        buf_vld_ff;
   logic [prd_pkg::WORD_W-1:0]  buf_word_ff;
   logic                        buf_start_ff;
   logic [prd_pkg::IDX_W-1:0]   idx_ff;

   prd_pkg::state_type          state_ff;
   prd_pkg::state_type          state_in;
   prd_pkg::run_type            run;

   logic                        rsp_vld_ff;
   logic [prd_pkg::WORD_W-1:0]  rsp_value_ff;
   logic [prd_pkg::COUNT_W-1:0] rsp_len_ff;
   logic                        rsp_done_ff;
   logic                        rsp_last_ff;

   logic                        out_free;
   logic                        advance;
   logic                        req_xfer;

   prd_step u_step (
      .word         (buf_word_ff),
      .start        (buf_start_ff),
      .idx          (idx_ff),
      .image_format (format_ff),
      .pixel_count  (count_ff),
      .state        (state_ff),
      .state_next   (state_in),
      .run          (run)
   );

   assign out_free       = !rsp_vld_ff || rsp_chan.ready;
   assign advance        = buf_vld_ff && (out_free || !run.emit);
   assign req_chan.ready = !buf_vld_ff || (advance && run.word_done);
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.pixel_value  = rsp_value_ff;
   assign rsp_chan.run_length   = rsp_len_ff;
   assign rsp_chan.image_done   = rsp_done_ff;
   assign rsp_chan.last_of_word = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= prd_pkg::FMT_RAW;
         count_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            prd_pkg::CSR_IMAGE_FORMAT: format_ff <= csr_wdata[prd_pkg::FMT_W-1:0];
            prd_pkg::CSR_PIXEL_COUNT:  count_ff  <= csr_wdata;
            default:                   count_ff  <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff <= 1'b0;
         idx_ff     <= '0;
      end else if (req_xfer) begin
         buf_vld_ff <= 1'b1;
         idx_ff     <= '0;
      end else if (advance) begin
         if (run.word_done) begin
            buf_vld_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         buf_word_ff  <= req_chan.data_word;
         buf_start_ff <= req_chan.image_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && run.emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && run.emit) begin
         rsp_value_ff <= run.pixel_value;
         rsp_len_ff   <= run.run_length;
         rsp_done_ff  <= run.image_done;
         rsp_last_ff  <= run.last_of_word;
      end
   end

endmodule

// ----- design/prd_step.sv -----
// ----------------------------------------------------------------------------
// prd_step
// One decode step on the buffered word: at most one run and the next state.
// ----------------------------------------------------------------------------
module prd_step (
   input  logic [prd_pkg::WORD_W-1:0]  word,
   input  logic                        start,
   input  logic [prd_pkg::IDX_W-1:0]   idx,
   input  logic [prd_pkg::FMT_W-1:0]   image_format,
   input  logic [prd_pkg::COUNT_W-1:0] pixel_count,
   input  prd_pkg::state_type          state,
   output prd_pkg::state_type          state_next,
   output prd_pkg::run_type            run
);

   logic                        first;
   logic [prd_pkg::COUNT_W-1:0] sat_count;
   logic [prd_pkg::COUNT_W-1:0] left;
   logic                        expect_count;
   logic                        need_fore;
   logic [prd_pkg::WORD_W-1:0]  argb;
   logic [prd_pkg::CODE_W-1:0]  code;
   logic [prd_pkg::LEN_W-1:0]   len0, len1, len2, len3;
   logic                        later_nz;
   logic [prd_pkg::WORD_W-1:0]  req_len;
   logic [prd_pkg::COUNT_W-1:0] clip_len;
   logic [prd_pkg::COUNT_W-1:0] left_after;

   assign first     = start && (idx == '0);
   assign sat_count = ({8'd0, pixel_count} > prd_pkg::MaxPixels)
                      ? prd_pkg::MaxPixels[prd_pkg::COUNT_W-1:0] : pixel_count;
   assign left         = first ? sat_count : state.pixels_left;
   assign expect_count = first ? 1'b0 : state.expect_count;
   assign need_fore    = first ? (image_format == prd_pkg::FMT_RLE1) : state.need_fore;
   assign argb         = {word[7:0], word[31:8]};

   assign len0 = word[30:24];
   assign len1 = word[22:16];
   assign len2 = word[14:8];
   assign len3 = word[6:0];

   always_comb begin
      unique case (idx)
         2'd0: begin
            code     = word[31:24];
            later_nz = (len1 != '0) || (len2 != '0) || (len3 != '0);
         end
         2'd1: begin
            code     = word[23:16];
            later_nz = (len2 != '0) || (len3 != '0);
         end
         2'd2: begin
            code     = word[15:8];
            later_nz = (len3 != '0);
         end
         default: begin
            code     = word[7:0];
            later_nz = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (image_format == prd_pkg::FMT_RLE) begin
         req_len = word;
      end else if (image_format == prd_pkg::FMT_RLE1) begin
         req_len = {25'd0, code[prd_pkg::LEN_W-1:0]};
      end else begin
         req_len = 32'd1;
      end
      clip_len   = (req_len < {7'd0, left}) ? req_len[prd_pkg::COUNT_W-1:0] : left;
      left_after = left - clip_len;
   end

   always_comb begin
      state_next              = state;
      state_next.pixels_left  = left;
      state_next.expect_count = expect_count;
      state_next.need_fore    = need_fore;
      run.emit         = 1'b0;
      run.word_done    = 1'b1;
      run.pixel_value  = argb;
      run.run_length   = clip_len;
      run.image_done   = (left_after == '0);
      run.last_of_word = 1'b1;
      if (left != '0) begin
         unique case (image_format)
            prd_pkg::FMT_RAW: begin
               run.emit               = 1'b1;
               state_next.pixels_left = left_after;
            end
            prd_pkg::FMT_RLE: begin
               if (!expect_count) begin
                  state_next.held_pixel   = argb;
                  state_next.expect_count = 1'b1;
               end else begin
                  state_next.expect_count = 1'b0;
                  run.pixel_value         = state.held_pixel;
                  if (word != '0) begin
                     run.emit               = 1'b1;
                     state_next.pixels_left = left_after;
                  end
               end
            end
            prd_pkg::FMT_RLE1: begin
               if (need_fore) begin
                  state_next.fore_colour = argb;
                  state_next.need_fore   = 1'b0;
               end else begin
                  run.pixel_value = code[prd_pkg::CODE_W-1] ? state.fore_colour : '0;
                  if (code[prd_pkg::LEN_W-1:0] != '0) begin
                     run.emit               = 1'b1;
                     state_next.pixels_left = left_after;
                     run.last_of_word       = (left_after == '0) || !later_nz;
                     run.word_done          = (idx == 2'd3) || (left_after == '0);
                  end else begin
                     run.word_done = (idx == 2'd3);
                  end
               end
            end
            default: begin
               run.emit = 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- tb/sv/prd_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// prd_tb_pkg
// Run record and scoreboard of the pixel map run decoder bench. The
// scoreboard keeps its own copy of the decoder registers and state, turns
// every accepted stream word into the pixel runs it should produce, and
// checks each delivered run field by field against the oldest one due.
// ----------------------------------------------------------------------------
package prd_tb_pkg;

   localparam int WORD_W    = prd_pkg::WORD_W;
   localparam int COUNT_W   = prd_pkg::COUNT_W;
   localparam int FMT_W     = prd_pkg::FMT_W;
   localparam int CODE_W    = prd_pkg::CODE_W;
   localparam int LEN_W     = prd_pkg::LEN_W;
   localparam int CODES     = prd_pkg::CODES;
   localparam int CSR_IDX_W = prd_pkg::CSR_IDX_W;

   localparam logic [FMT_W-1:0] FMT_UNDEFINED = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0]  pixel_value;
      logic [COUNT_W-1:0] run_length;
      logic               image_done;
      logic               last_of_word;
   } pixel_run_type;

   class prd_run_scoreboard;
      logic [FMT_W-1:0]   image_format_reg = prd_pkg::FMT_RAW;
      logic [COUNT_W-1:0] pixel_count_reg  = '0;
      logic [COUNT_W-1:0] left_to_fill     = '0;
      logic               awaiting_count   = 1'b0;
      logic [WORD_W-1:0]  pending_pixel    = '0;
      logic [WORD_W-1:0]  foreground       = '0;
      logic               awaiting_fore    = 1'b0;
      pixel_run_type      runs_due[$];
      int                 errors           = 0;

      task report(string what);
         $display("ERROR: %s", what);
         errors++;
      endtask

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [COUNT_W-1:0] value);
         if (index == prd_pkg::CSR_IMAGE_FORMAT) begin
            image_format_reg = value[FMT_W-1:0];
         end else begin
            pixel_count_reg = value;
         end
      endfunction

      function logic [WORD_W-1:0] argb_of(logic [WORD_W-1:0] word);
         return {word[7:0], word[WORD_W-1:8]};
      endfunction

      function void add_run(logic [WORD_W-1:0] value, logic [WORD_W-1:0] len,
                            ref pixel_run_type word_runs[$]);
         pixel_run_type      run;
         logic [COUNT_W-1:0] take;
         take = (len < {{(WORD_W-COUNT_W){1'b0}}, left_to_fill}) ? COUNT_W'(len) : left_to_fill;
         left_to_fill     = left_to_fill - take;
         run.pixel_value  = value;
         run.run_length   = take;
         run.image_done   = (left_to_fill == '0);
         run.last_of_word = 1'b0;
         word_runs.push_back(run);
      endfunction

      // Return 1 when the word is decoded rather than ignored.
      function bit decode_word(logic [WORD_W-1:0] word, logic start);
         pixel_run_type     word_runs[$];
         logic [CODE_W-1:0] code;
         if (start) begin
            left_to_fill   = ({8'd0, pixel_count_reg} > prd_pkg::MaxPixels)
                             ? COUNT_W'(prd_pkg::MaxPixels) : pixel_count_reg;
            awaiting_count = 1'b0;
            awaiting_fore  = (image_format_reg == prd_pkg::FMT_RLE1);
         end
         if (left_to_fill == '0 || image_format_reg == FMT_UNDEFINED) return 1'b0;
         case (image_format_reg)
            prd_pkg::FMT_RAW: begin
               add_run(argb_of(word), 1, word_runs);
            end
            prd_pkg::FMT_RLE: begin
               if (!awaiting_count) begin
                  pending_pixel  = argb_of(word);
                  awaiting_count = 1'b1;
               end else begin
                  awaiting_count = 1'b0;
                  if (word != '0) add_run(pending_pixel, word, word_runs);
               end
            end
            default: begin
               if (awaiting_fore) begin
                  foreground    = argb_of(word);
                  awaiting_fore = 1'b0;
               end else begin
                  for (int slot = CODES - 1; slot >= 0; slot--) begin
                     code = word[slot*CODE_W +: CODE_W];
                     if (code[LEN_W-1:0] != '0 && left_to_fill != '0) begin
                        add_run(code[LEN_W] ? foreground : '0,
                                WORD_W'(code[LEN_W-1:0]), word_runs);
                     end
                  end
               end
            end
         endcase
         if (word_runs.size() != 0) word_runs[word_runs.size()-1].last_of_word = 1'b1;
         foreach (word_runs[k]) runs_due.push_back(word_runs[k]);
         return 1'b1;
      endfunction

      task check_run(pixel_run_type got);
         pixel_run_type due;
         if (runs_due.size() == 0) begin
            report($sformatf("run with none due: value %h length %0d",
                             got.pixel_value, got.run_length));
            return;
         end
         due = runs_due.pop_front();
         if (got.pixel_value !== due.pixel_value)
            report($sformatf("pixel_value %h, want %h", got.pixel_value, due.pixel_value));
         if (got.run_length !== due.run_length)
            report($sformatf("run_length %0d, want %0d", got.run_length, due.run_length));
         if (got.image_done !== due.image_done)
            report($sformatf("image_done %b, want %b", got.image_done, due.image_done));
         if (got.last_of_word !== due.last_of_word)
            report($sformatf("last_of_word %b, want %b", got.last_of_word, due.last_of_word));
      endtask

      task close();
         if (runs_due.size() != 0)
            report($sformatf("%0d runs never delivered", runs_due.size()));
      endtask
   endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Bench for the pixel map run decoder. A directed set covers the field
// extremes, every format, zero lengths, clipping, completed images, format
// changes mid-image and the undefined format; random phases then send
// well-formed images with random content, restarts and stray words, with
// bursty input, a patterned result stall and repeated long result hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_W    = prd_pkg::WORD_W;
   localparam int COUNT_W   = prd_pkg::COUNT_W;
   localparam int FMT_W     = prd_pkg::FMT_W;
   localparam int CODE_W    = prd_pkg::CODE_W;
   localparam int LEN_W     = prd_pkg::LEN_W;
   localparam int CODES     = prd_pkg::CODES;
   localparam int CSR_IDX_W = prd_pkg::CSR_IDX_W;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TOTAL_WORDS    = 420;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COUNT_W-1:0]   csr_wdata;

   prd_req_if req_chan();
   prd_rsp_if rsp_chan();

   prd_tb_pkg::prd_run_scoreboard sb = new();

   int         burst_left   = 6;
   bit         hold_request = 1'b0;
   int         hold_left    = 0;
   logic [7:0] stall_tick   = '0;
   int         idle_cycles  = 0;
   int         words_sent   = 0;

   pixmap_run_decoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            void'(sb.decode_word(req_chan.data_word, req_chan.image_start));
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_run('{pixel_value:  rsp_chan.pixel_value,
                           run_length:   rsp_chan.run_length,
                           image_done:   rsp_chan.image_done,
                           last_of_word: rsp_chan.last_of_word});
      end
   end

   always @(posedge clock) begin
      stall_tick++;
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 80;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         case (stall_tick[7:6])
            2'd0:    rsp_chan.ready <= 1'b1;
            2'd1:    rsp_chan.ready <= 1'($urandom);
            2'd2:    rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_chan.ready <= (stall_tick[2:0] != 3'd5);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_word(input logic [WORD_W-1:0] word, input logic start);
      int gap;
      req_chan.valid       <= 1'b1;
      req_chan.data_word   <= word;
      req_chan.image_start <= start;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      words_sent++;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   // Hold the input until every run due has arrived and the last word has cleared.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.runs_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic configure(input logic [FMT_W-1:0] fmt, input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] fmt_word;
      fmt_word = COUNT_W'(fmt);
      if ($urandom_range(0, 3) == 0) fmt_word[COUNT_W-1:FMT_W] = (COUNT_W - FMT_W)'($urandom);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= prd_pkg::CSR_IMAGE_FORMAT;
      csr_wdata <= fmt_word;
      @(posedge clock);
      csr_index <= prd_pkg::CSR_PIXEL_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_register(prd_pkg::CSR_IMAGE_FORMAT, fmt_word);
      sb.set_register(prd_pkg::CSR_PIXEL_COUNT, count);
   endtask

   initial begin
      logic [FMT_W-1:0]   fmt;
      logic [COUNT_W-1:0] count;
      logic [WORD_W-1:0]  word;
      logic [LEN_W-1:0]   len;
      logic               start;
      int                 phase;
      int                 words;

      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = prd_pkg::CSR_IMAGE_FORMAT;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.data_word   = '0;
      req_chan.image_start = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // raw pixels, completion, then a stray word
      configure(prd_pkg::FMT_RAW, 25'd3);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h1234_5678, 1'b0);
      send_word(32'hA5A5_A5A5, 1'b0);
      // pairs at the largest image: zero count, clipped count
      configure(prd_pkg::FMT_RLE, COUNT_W'(prd_pkg::MaxPixels));
      send_word(32'h8000_0001, 1'b1);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'h7F00_FF80, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h1111_1111, 1'b0);
      // packed runs: empty codes, clip, codes dropped after completion
      configure(prd_pkg::FMT_RLE1, 25'd10);
      send_word(32'hDEAD_BEEF, 1'b1);
      send_word(32'h0080_0000, 1'b0);
      send_word(32'h8300_05FF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      // format change between pixel and count words
      configure(prd_pkg::FMT_RLE, 25'd200);
      send_word(32'hCAFE_F00D, 1'b1);
      configure(prd_pkg::FMT_RAW, 25'd200);
      send_word(32'h0102_0304, 1'b0);
      configure(prd_pkg::FMT_RLE, 25'd200);
      send_word(32'h0000_0005, 1'b0);
      // undefined format, then a count change that waits for the next start
      configure(prd_tb_pkg::FMT_UNDEFINED, 25'd5);
      send_word(32'h0000_0001, 1'b1);
      send_word(32'h0000_0002, 1'b0);
      configure(prd_pkg::FMT_RAW, 25'd0);
      send_word(32'h0000_0003, 1'b0);
      send_word(32'h0000_0004, 1'b1);
      // oversized count saturates; four runs from one word
      configure(prd_pkg::FMT_RAW, '1);
      send_word(32'h89AB_CDEF, 1'b1);
      configure(prd_pkg::FMT_RLE1, 25'd300);
      send_word(32'h0F1E_2D3C, 1'b1);
      send_word(32'h817F_8304, 1'b0);

      phase = 0;
      while (words_sent < TOTAL_WORDS) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:        fmt = prd_pkg::FMT_RAW;
            6, 7, 8, 9, 10, 11:      fmt = prd_pkg::FMT_RLE;
            19:                      fmt = prd_tb_pkg::FMT_UNDEFINED;
            default:                 fmt = prd_pkg::FMT_RLE1;
         endcase
         case ($urandom_range(0, 15))
            0:       count = '0;
            1:       count = COUNT_W'(prd_pkg::MaxPixels);
            2:       count = '1;
            3:       count = COUNT_W'($urandom);
            default: count = COUNT_W'($urandom_range(1, 40));
         endcase
         if (phase % 5 == 1) begin
            fmt   = prd_pkg::FMT_RLE1;
            count = COUNT_W'(prd_pkg::MaxPixels);
         end
         configure(fmt, count);
         if (phase % 5 == 1) hold_request = 1'b1;
         repeat ($urandom_range(1, 3)) begin
            words = $urandom_range(2, 14);
            for (int w = 0; w < words; w++) begin
               start = (w == 0) || ($urandom_range(0, 24) == 0);
               word  = $urandom;
               if (fmt == prd_pkg::FMT_RLE && w % 2 == 1) begin
                  case ($urandom_range(0, 9))
                     0:       word = '0;
                     1:       word = $urandom;
                     default: word = $urandom_range(1, 12);
                  endcase
               end else if (fmt == prd_pkg::FMT_RLE1 && w != 0) begin
                  for (int slot = 0; slot < CODES; slot++) begin
                     case ($urandom_range(0, 9))
                        0:       len = '0;
                        1:       len = '1;
                        2:       len = LEN_W'($urandom);
                        default: len = LEN_W'($urandom_range(1, 6));
                     endcase
                     word[slot*CODE_W +: CODE_W] = {1'($urandom), len};
                  end
               end
               send_word(word, start);
            end
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);
         end
         phase++;
      end

      drain();
      sb.close();
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
